>>> sv/rtpg_pkg.sv
// ----------------------------------------------------------------------------
// rtpg_pkg
// Shared types, codes, color tables and small constant dividers for the
// raster test-pattern generator.
// ----------------------------------------------------------------------------
package rtpg_pkg;

	// position values are carried at this width inside the pattern logic
	localparam int POS_W      = 10;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'd1;

	// pattern codes
	localparam logic [2:0] MODE_MONO_CHECK   = 3'd0;
	localparam logic [2:0] MODE_STRIPE_CHECK = 3'd1;
	localparam logic [2:0] MODE_BANDS        = 3'd2;
	localparam logic [2:0] MODE_CROSS        = 3'd3;
	localparam logic [2:0] MODE_XOR_FRAME    = 3'd4;
	localparam logic [2:0] MODE_PROD_FRAME   = 3'd5;
	localparam logic [2:0] MODE_CHAOS        = 3'd6;
	localparam logic [2:0] MODE_XY           = 3'd7;

	// multiplier operand selection
	localparam logic [1:0] MUL_FIRST = 2'd0;	// pattern's own product
	localparam logic [1:0] MUL_RECIP = 2'd1;	// |p|/32 times reciprocal of 25
	localparam logic [1:0] MUL_SCALE = 2'd2;	// signed quotient times frame count

	// ceil(2^31 / 25): (m * RECIP_800) >> 31 == m / 25 for m <= 2^26
	localparam logic [31:0] RECIP_800 = 32'd85899346;

	localparam logic [7:0] BLACK = 8'h00;
	localparam logic [7:0] WHITE = 8'hFF;

	typedef struct packed {
		logic               frame_start;
		logic signed [31:0] frame_count;
		logic signed [31:0] chaos_sample;
	} req_t;

	typedef struct packed {
		logic [17:0] pixel_index;
		logic [7:0]  color;
		logic        frame_end;
	} pix_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_op;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_mul;
		logic chaos;
	} status_t;

	// RGB332 color table
	function automatic logic [7:0] palette(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h00;
			3'd1: c = 8'h07;
			3'd2: c = 8'h3F;
			3'd3: c = 8'h38;
			3'd4: c = 8'hF8;
			3'd5: c = 8'h0F;
			3'd6: c = 8'hC0;
			3'd7: c = 8'hFF;
		endcase
		return c;
	endfunction

	// v / 24 for v < 1024: (v >> 3) / 3 by reciprocal 43 / 128
	function automatic logic [5:0] div24(input logic [POS_W-1:0] v);
		logic [12:0] p;
		p = 13'(v[POS_W-1:3]) * 13'd43;
		return p[12:7];
	endfunction

	// v / 60 for v < 1024: (v >> 2) / 15 by reciprocal 274 / 4096
	function automatic logic [4:0] div60(input logic [POS_W-1:0] v);
		logic [16:0] p;
		p = 17'(v[POS_W-1:2]) * 17'd274;
		return p[16:12];
	endfunction

endpackage

>>> sv/raster_test_pattern_generator.sv
// ----------------------------------------------------------------------------
// raster_test_pattern_generator
// Raster-order test-pattern source, one pixel per request item.
// ----------------------------------------------------------------------------
// Each accepted request yields one pixel (index, RGB332 color, end-of-frame
// mark) in raster order over a FRAME_W by FRAME_H frame. The controller walks
// each item through the single shared 32x32 multiplier as its pattern needs
// (one product per cycle): no product for patterns 0 to 3, one for patterns
// 4, 5 and 7, and three in a row for the chaos pattern 6 (its product, the
// division by 800 and the scaling by frame count). A finished pixel sits in an
// output register, so the next request is taken while it waits. Write
// pattern_mode (index 0) and shift_amount (index 1) only while no pixel is
// in flight.
module raster_test_pattern_generator #(
	parameter int FRAME_W = 320,
	parameter int FRAME_H = 480
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  rtpg_pkg::req_t                  req,
	output logic                            pix_valid,
	input  logic                            pix_ready,
	output rtpg_pkg::pix_t                  pix,
	input  logic                            cfg_we,
	input  logic [rtpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtpg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rtpg_pkg::*;

	cmd_t    cmd;
	status_t status;

	rtpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rtpg_dp #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.pix       (pix)
	);

endmodule

>>> sv/rtpg_ctrl.sv
// ----------------------------------------------------------------------------
// rtpg_ctrl
// Sequencer for the pattern generator: takes an item, steps the shared
// multiplier as the pattern needs, and manages the output register.
// ----------------------------------------------------------------------------
module rtpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              pix_valid,
	input  logic              pix_ready,
	input  rtpg_pkg::status_t status,
	output rtpg_pkg::cmd_t    cmd
);
	import rtpg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_FC   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign req_ready = (state_q == S_IDLE);
	assign pix_valid = out_valid_q;
	assign out_free  = !out_valid_q || pix_ready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.mul_op   = MUL_FIRST;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = status.needs_mul ? S_MUL : S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_FIRST;
				state_d    = status.chaos ? S_DIV : S_FIN;
			end
			S_DIV: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_RECIP;
				state_d    = S_FC;
			end
			S_FC: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_SCALE;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (pix_ready)
				out_valid_q <= 1'b0;
		end
	end

	// a result is never written over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || pix_ready))
		else $error("output register overwritten");

	// an accepted item always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("item accepted but controller stayed idle");

	// the division step is always followed by the scaling step
	a_div_then_fc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |=> (state_q == S_FC))
		else $error("chaos sequence broken");

	// a new result only appears out of the finishing step
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result shown outside finishing step");

endmodule

>>> sv/rtpg_dp.sv
// ----------------------------------------------------------------------------
// rtpg_dp
// Datapath: raster and stripe counters, configuration registers, item
// registers, shared 32x32 multiplier and the output register.
// ----------------------------------------------------------------------------
module rtpg_dp #(
	parameter int FRAME_W = 320,
	parameter int FRAME_H = 480
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rtpg_pkg::req_t                     req,
	input  logic                               cfg_we,
	input  logic [rtpg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtpg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  rtpg_pkg::cmd_t                     cmd,
	output rtpg_pkg::status_t                  status,
	output rtpg_pkg::pix_t                     pix
);
	import rtpg_pkg::*;

	localparam int COL_W   = $clog2(FRAME_W);
	localparam int ROW_W   = $clog2(FRAME_H);
	localparam int IDX_W   = $clog2(FRAME_W * FRAME_H);
	localparam int SC_LIM  = FRAME_W / 16;
	localparam int SR_LIM  = FRAME_H / 16;
	localparam int SC_W    = $clog2(SC_LIM + 1);
	localparam int SR_W    = $clog2(SR_LIM + 1);

	// configuration
	logic [2:0] pattern_mode_q;
	logic [4:0] shift_amount_q;

	// raster and stripe state
	logic [COL_W-1:0] col_q, col_e, col_d;
	logic [ROW_W-1:0] row_q, row_e, row_d;
	logic [IDX_W-1:0] idx_q, idx_e, idx_d;
	logic [SC_W-1:0]  scc_q, scc_e, scc_d;
	logic [SR_W-1:0]  src_q, src_e, src_d;
	logic [2:0]       sci_q, sci_e, sci_d;
	logic             last_e;

	// item registers
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [31:0]       fc_s1;
	logic [31:0]       cs_s1;
	logic [7:0]        color_s1;
	logic              last_s1;

	// multiplier
	logic [63:0] product_q;
	logic        sign_q;
	logic [31:0] mul_a, mul_b;
	logic [31:0] x32, y32, p_lo, mag, quo, quo_s;

	// pattern logic at load
	logic [POS_W-1:0] x10, y10;
	logic [5:0]       y_div24;
	logic [4:0]       y_div60;
	logic [7:0]       color_e;
	logic [31:0]      shifted;
	logic [7:0]       color_f;

	assign status.needs_mul = pattern_mode_q[2];
	assign status.chaos     = (pattern_mode_q == MODE_CHAOS);

	// colored cross on white
	function automatic logic [7:0] cross_color(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y);
		logic [7:0] c;
		if (y > 10'd230 && y < 10'd250 && x > 10'd155 && x < 10'd165)
			c = WHITE;
		else if (y > 10'd80 && y < 10'd400 && x > 10'd140 && x < 10'd180)
			c = palette(3'(x[7:5] + 3'd1));
		else if (y > 10'd200 && y < 10'd280 && x > 10'd40 && x < 10'd280)
			c = palette(3'(y[7:5] + 3'd3));
		else
			c = WHITE;
		return c;
	endfunction

	// frame start applies before this pixel, then stripe update and next raster
	always_comb begin
		col_e = req.frame_start ? '0 : col_q;
		row_e = req.frame_start ? '0 : row_q;
		idx_e = req.frame_start ? '0 : idx_q;
		scc_e = req.frame_start ? '0 : scc_q;
		src_e = req.frame_start ? '0 : src_q;
		sci_e = req.frame_start ? '0 : sci_q;

		scc_d = scc_e;
		src_d = src_e;
		sci_d = sci_e;
		if (col_e == '0) begin
			if (src_d == SR_W'(SR_LIM)) begin
				src_d = '0;
				sci_d = 3'(sci_d + 3'd3);
			end
			src_d = SR_W'(src_d + 1'b1);
		end
		if (scc_d == SC_W'(SC_LIM)) begin
			scc_d = '0;
			sci_d = 3'(sci_d + 3'd1);
		end
		scc_d = SC_W'(scc_d + 1'b1);

		last_e = (col_e == COL_W'(FRAME_W - 1)) && (row_e == ROW_W'(FRAME_H - 1));
		if (col_e == COL_W'(FRAME_W - 1)) begin
			col_d = '0;
			row_d = last_e ? '0 : ROW_W'(row_e + 1'b1);
		end else begin
			col_d = COL_W'(col_e + 1'b1);
			row_d = row_e;
		end
		idx_d = last_e ? '0 : IDX_W'(idx_e + 1'b1);

		x10 = POS_W'(col_e);
		y10 = POS_W'(row_e);
		y_div24 = div24(y10);
		y_div60 = div60(y10);
		unique case (pattern_mode_q)
			MODE_MONO_CHECK:   color_e = (y_div24[0] ^ x10[4]) ? WHITE : BLACK;
			MODE_STRIPE_CHECK: color_e = palette(sci_d);
			MODE_BANDS:        color_e = palette(y_div60[2:0]);
			MODE_CROSS:        color_e = cross_color(x10, y10);
			default:           color_e = BLACK;
		endcase

		// frame wrap clears the stripe state once this pixel's color is taken
		if (last_e) begin
			scc_d = '0;
			src_d = '0;
			sci_d = '0;
		end
	end

	// configuration writes and raster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q <= '0;
			shift_amount_q <= '0;
			col_q          <= '0;
			row_q          <= '0;
			idx_q          <= '0;
			scc_q          <= '0;
			src_q          <= '0;
			sci_q          <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_PATTERN_MODE)
				pattern_mode_q <= cfg_data[2:0];
			if (cfg_we && cfg_index == REG_SHIFT_AMOUNT)
				shift_amount_q <= cfg_data[4:0];
			if (cmd.load) begin
				col_q <= col_d;
				row_q <= row_d;
				idx_q <= idx_d;
				scc_q <= scc_d;
				src_q <= src_d;
				sci_q <= sci_d;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_s1   <= col_e;
			row_s1   <= row_e;
			idx_s1   <= idx_e;
			fc_s1    <= req.frame_count;
			cs_s1    <= req.chaos_sample;
			color_s1 <= color_e;
			last_s1  <= last_e;
		end
	end

	// multiplier operands
	always_comb begin
		x32   = 32'(col_s1);
		y32   = 32'(row_s1);
		p_lo  = product_q[31:0];
		mag   = p_lo[31] ? (~p_lo + 32'd1) : p_lo;
		quo   = product_q[62:31];
		quo_s = sign_q ? (~quo + 32'd1) : quo;
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			MUL_FIRST: begin
				unique case (pattern_mode_q)
					MODE_XOR_FRAME: begin
						mul_a = y32 ^ ~(x32 << 1);
						mul_b = fc_s1;
					end
					MODE_PROD_FRAME: begin
						mul_a = ((y32 << 8) - y32) ^ ((x32 << 8) - x32);
						mul_b = ~fc_s1;
					end
					MODE_CHAOS: begin
						mul_a = 32'(idx_s1);
						mul_b = cs_s1;
					end
					default: begin
						mul_a = y32;
						mul_b = x32;
					end
				endcase
			end
			MUL_RECIP: begin
				mul_a = 32'(mag[31:5]);
				mul_b = RECIP_800;
			end
			MUL_SCALE: begin
				mul_a = quo_s;
				mul_b = fc_s1;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			product_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.mul_en && cmd.mul_op == MUL_RECIP)
			sign_q <= p_lo[31];
	end

	// final color select
	always_comb begin
		shifted = 32'($signed(product_q[31:0]) >>> shift_amount_q);
		unique case (pattern_mode_q)
			MODE_XOR_FRAME:  color_f = product_q[23:16];
			MODE_PROD_FRAME,
			MODE_CHAOS,
			MODE_XY:         color_f = shifted[7:0];
			default:         color_f = color_s1;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pix.pixel_index <= 18'(idx_s1);
			pix.color       <= color_f;
			pix.frame_end   <= last_s1;
		end
	end

endmodule

>>> verif/tb_raster_test_pattern_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_test_pattern_generator
// Self-checking bench: a short table of hand-picked pixels, a stretch of
// pixels walked through the patterns in turn, then random mixed traffic,
// under random stalls, checked against typed rows or an in-bench model.
// ----------------------------------------------------------------------------
module tb_raster_test_pattern_generator;
	import rtpg_pkg::*;

	localparam int FRAME_W     = 320;
	localparam int FRAME_H     = 480;
	localparam int CYCLE_ITEMS  = 320;
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_TAIL   = 200;

	// RGB332 color table of the pattern set
	localparam logic [7:0] HUE [8] = '{8'h00, 8'h07, 8'h3F, 8'h38, 8'hF8, 8'h0F, 8'hC0, 8'hFF};

	typedef struct {
		logic [2:0] mode;
		logic [4:0] shift;
		req_t       rq;
		bit         typed;
		pix_t       want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	pix_t pix;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state: configuration, raster position, stripe counters
	logic [2:0] mdl_mode = MODE_MONO_CHECK;
	logic [4:0] mdl_shift = '0;
	logic [8:0] ras_col = '0;
	logic [8:0] ras_row = '0;
	logic [5:0] stripe_cols = '0;
	logic [4:0] stripe_rows = '0;
	logic [2:0] stripe_hue = '0;

	pix_t pending_pixels [$];
	int   fail_count = 0;
	bit   stall_on = 1'b1;
	int   rx_hold = 0;

	// directed pixels; rows marked typed carry their expected pixel
	dir_row_t dir_rows [21] = '{
		'{MODE_MONO_CHECK,   5'd0,  '{1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{18'd0, BLACK, 1'b0}},
		'{MODE_MONO_CHECK,   5'd0,  '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
		'{MODE_STRIPE_CHECK, 5'd0,  '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
			'{18'd0, BLACK, 1'b0}},
		'{MODE_BANDS,        5'd0,  '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
		'{MODE_CROSS,        5'd0,  '{1'b1, 32'h0000_0001, 32'h0000_0001}, 1'b1,
			'{18'd0, WHITE, 1'b0}},
		'{MODE_XOR_FRAME,    5'd0,  '{1'b1, 32'h0000_0001, 32'h0000_0000}, 1'b1,
			'{18'd0, 8'hFF, 1'b0}},
		'{MODE_XOR_FRAME,    5'd0,  '{1'b0, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b0, '0},
		'{MODE_XOR_FRAME,    5'd0,  '{1'b0, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b0, '0},
		'{MODE_PROD_FRAME,   5'd0,  '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{18'd0, BLACK, 1'b0}},
		'{MODE_PROD_FRAME,   5'd0,  '{1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{MODE_PROD_FRAME,   5'd31, '{1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
		'{MODE_PROD_FRAME,   5'd16, '{1'b0, 32'h8000_0000, 32'h0000_0000}, 1'b0, '0},
		'{MODE_CHAOS,        5'd0,  '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
			'{18'd0, BLACK, 1'b0}},
		'{MODE_CHAOS,        5'd0,  '{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0},
		'{MODE_CHAOS,        5'd0,  '{1'b0, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
		'{MODE_CHAOS,        5'd31, '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
		'{MODE_CHAOS,        5'd7,  '{1'b0, 32'h0001_2345, 32'h7FFF_FFFF}, 1'b0, '0},
		'{MODE_XY,           5'd0,  '{1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{18'd0, BLACK, 1'b0}},
		'{MODE_XY,           5'd0,  '{1'b0, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '0},
		'{MODE_XY,           5'd31, '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, '0},
		'{MODE_BANDS,        5'd0,  '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{18'd0, BLACK, 1'b0}}
	};

	raster_test_pattern_generator #(
		.FRAME_W(FRAME_W),
		.FRAME_H(FRAME_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// arithmetic right shift, zero shift passes through
	function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction

	// cross pattern: white center, vertical bar, horizontal bar, white field
	function automatic logic [7:0] cross_hue(input logic [31:0] x, input logic [31:0] y);
		if (y > 230 && y < 250 && x > 155 && x < 165)
			return WHITE;
		if (y > 80 && y < 400 && x > 140 && x < 180)
			return HUE[3'((x / 32) + 1)];
		if (y > 200 && y < 280 && x > 40 && x < 280)
			return HUE[3'((y / 32) + 3)];
		return WHITE;
	endfunction

	// next pixel in raster order; advances position and stripe counters
	function automatic pix_t next_pixel(input req_t r);
		logic [31:0] x, y, idx, fc, cs, q, c;
		pix_t p;
		fc = r.frame_count;
		cs = r.chaos_sample;
		if (r.frame_start) begin
			ras_col = '0;
			ras_row = '0;
			stripe_cols = '0;
			stripe_rows = '0;
			stripe_hue = '0;
		end
		x = 32'(ras_col);
		y = 32'(ras_row);
		idx = y * FRAME_W + x;

		// stripe counters run in every mode
		if (x == 0) begin
			if (stripe_rows == 5'(FRAME_H / 16)) begin
				stripe_rows = '0;
				stripe_hue = stripe_hue + 3'd3;
			end
			stripe_rows = stripe_rows + 5'd1;
		end
		if (stripe_cols == 6'(FRAME_W / 16)) begin
			stripe_cols = '0;
			stripe_hue = stripe_hue + 3'd1;
		end
		stripe_cols = stripe_cols + 6'd1;

		case (mdl_mode)
			MODE_MONO_CHECK:   c = (((y / 24) ^ (x / 16)) & 1) != 0 ? WHITE : BLACK;
			MODE_STRIPE_CHECK: c = HUE[stripe_hue];
			MODE_BANDS:        c = HUE[3'(y / 60)];
			MODE_CROSS:        c = cross_hue(x, y);
			MODE_XOR_FRAME:    c = ((y ^ ~(x * 2)) * fc) >> 16;
			MODE_PROD_FRAME:   c = sra32(((y * 255) ^ (x * 255)) * ~fc, mdl_shift);
			MODE_CHAOS: begin
				q = 32'($signed(idx * cs) / 32'sd800);
				c = sra32(q * fc, mdl_shift);
			end
			default:           c = sra32(y * x, mdl_shift);
		endcase

		p.pixel_index = idx[17:0];
		p.color = c[7:0];
		p.frame_end = (x == FRAME_W - 1) && (y == FRAME_H - 1);

		// raster advance, frame wrap clears stripes like a frame start
		if (x + 1 >= FRAME_W) begin
			ras_col = '0;
			if (y + 1 >= FRAME_H) begin
				ras_row = '0;
				stripe_cols = '0;
				stripe_rows = '0;
				stripe_hue = '0;
			end else begin
				ras_row = 9'(y + 1);
			end
		end else begin
			ras_col = 9'(x + 1);
		end
		return p;
	endfunction

	// random word, weighted toward the extremes
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] pick_shift();
		case ($urandom_range(0, 3))
			0: return 5'd0;
			1: return 5'd31;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	// offer one item and hold it until taken; valid stays high afterwards
	task automatic send_item(input req_t r, input bit typed, input pix_t want);
		pix_t p;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		p = next_pixel(r);
		pending_pixels.push_back(typed ? want : p);
	endtask

	// occasional random sender gap with req_valid low
	task automatic sender_gap();
		if (stall_on && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// stop offering, let every pixel come out, then write both registers
	task automatic set_config(input logic [2:0] mode, input logic [4:0] shift);
		@(negedge clk);
		req_valid <= 1'b0;
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PATTERN_MODE;
		cfg_data <= CFG_DATA_W'(mode);
		@(negedge clk);
		cfg_index <= REG_SHIFT_AMOUNT;
		cfg_data <= shift;
		@(negedge clk);
		cfg_we <= 1'b0;
		mdl_mode = mode;
		mdl_shift = shift;
	endtask

	// receiver stalls in random bursts while stalls are on
	always @(negedge clk) begin
		if (!stall_on) begin
			pix_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			pix_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			pix_ready <= 1'b0;
			rx_hold = $urandom_range(0, 3);
		end else begin
			pix_ready <= 1'b1;
		end
	end

	// pixel checker
	always @(posedge clk) begin : check_pixel
		pix_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel, pixel_index %0d", pix.pixel_index);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pix.pixel_index !== want.pixel_index) begin
					$error("pixel_index: expected %0d, got %0d",
						want.pixel_index, pix.pixel_index);
					fail_count++;
				end
				if (pix.color !== want.color) begin
					$error("color: expected %02h, got %02h (pixel_index %0d)",
						want.color, pix.color, want.pixel_index);
					fail_count++;
				end
				if (pix.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b (pixel_index %0d)",
						want.frame_end, pix.frame_end, want.pixel_index);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int   sent;
		int   total;
		int   n;
		int   phase;
		bit   fixed_fc;
		req_t r;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, configuration rewritten where a row changes it
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != mdl_mode || dir_rows[i].shift != mdl_shift)
				set_config(dir_rows[i].mode, dir_rows[i].shift);
			send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
			sender_gap();
		end

		// a run from a frame start, patterns cycled per stretch
		total = CYCLE_ITEMS;
		sent = 0;
		phase = 0;
		while (sent < total) begin
			n = $urandom_range(30, 50);
			if (n > total - sent)
				n = total - sent;
			set_config(3'(phase % 8), pick_shift());
			stall_on = $urandom_range(0, 3) != 0;
			fixed_fc = $urandom_range(0, 3) != 0;
			r.frame_count = rand_word();
			repeat (n) begin
				r.frame_start = (sent == 0);
				if (!fixed_fc)
					r.frame_count = rand_word();
				r.chaos_sample = rand_word();
				send_item(r, 1'b0, '0);
				sender_gap();
				sent++;
			end
			phase++;
		end

		// random mix with occasional frame restarts, quiet at the end
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			n = $urandom_range(10, 100);
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			set_config(3'($urandom_range(0, 7)), pick_shift());
			stall_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && $urandom_range(0, 4) != 0;
			fixed_fc = $urandom_range(0, 1) != 0;
			r.frame_count = rand_word();
			repeat (n) begin
				r.frame_start = $urandom_range(0, 39) == 0;
				if (!fixed_fc)
					r.frame_count = rand_word();
				r.chaos_sample = rand_word();
				send_item(r, 1'b0, '0);
				sender_gap();
				sent++;
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("raster_test_pattern_generator: match");
		else
			$display("raster_test_pattern_generator: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("raster_test_pattern_generator: mismatch");
		$finish;
	end

endmodule
